// ===== sv/vfws_pkg.sv =====
`default_nettype none

package vfws_pkg;

    localparam int FIFO_DEPTH        = 16;
    localparam int BLOCK_SIZE        = 1024;
    localparam int FIELDS_PER_SECOND = 50;
    localparam int SECONDS_PER_DAY   = 60 * 60 * 24;

    localparam int TICK_W  = 20;
    localparam int UTC_W   = 17;
    localparam int FCNT_W  = 6;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int ADDR_W  = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0] VBI_RESET  = TICK_W'(15625 + 1024);
    localparam logic [TICK_W-1:0] FILL_RESET = TICK_W'(288000);
    localparam logic [TICK_W-1:0] WARN_RESET = TICK_W'(32000);
    localparam logic [UTC_W-1:0]  UTC_RESET  = UTC_W'(36000);

    typedef enum logic [1:0] {
        OP_FIELD = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VBI  = 2'd0,
        CFG_FILL = 2'd1,
        CFG_WARN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              expire;
        logic [TICK_W-1:0] count;
    } t_timer_res;

endpackage

`default_nettype wire

// ===== sv/vfws_in_if.sv =====
`default_nettype none

interface vfws_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic                       field_pin;
    logic [vfws_pkg::PTR_W-1:0] write_index;

    modport source (output valid, output op, output field_pin, output write_index,
                    input ready);
    modport sink   (input valid, input op, input field_pin, input write_index,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/vfws_out_if.sv =====
`default_nettype none

interface vfws_out_if;
    logic                        valid;
    logic                        ready;
    logic [vfws_pkg::UTC_W-1:0]  utc_seconds;
    logic                        vbi_done;
    logic                        overrun;
    logic                        fifo_busy;
    logic [vfws_pkg::PTR_W-1:0]  read_index;
    logic                        start_read;
    logic [vfws_pkg::ADDR_W-1:0] read_address;
    logic                        tx_select;

    modport source (output valid, output utc_seconds, output vbi_done, output overrun,
                    output fifo_busy, output read_index, output start_read,
                    output read_address, output tx_select, input ready);
    modport sink   (input valid, input utc_seconds, input vbi_done, input overrun,
                    input fifo_busy, input read_index, input start_read,
                    input read_address, input tx_select, output ready);
endinterface

`default_nettype wire

// ===== sv/vfws_tick_timer.sv =====
`default_nettype none

module vfws_tick_timer (
    input  wire logic                       i_running,
    input  wire logic [vfws_pkg::TICK_W-1:0] i_count,
    input  wire logic [vfws_pkg::TICK_W-1:0] i_period,
    output vfws_pkg::t_timer_res            o_res
);

    always_comb begin
        o_res.expire = i_running && (i_count >= i_period);
        if (o_res.expire) begin
            o_res.count = '0;
        end else if (i_running) begin
            o_res.count = i_count + vfws_pkg::TICK_W'(1);
        end else begin
            o_res.count = i_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vbi_fifo_window_scheduler_core.sv =====
`default_nettype none

// Field and tick scheduler for a VBI insertion path. Items are field edges, clock
// ticks and clears of the done flag; every item yields one result with the state
// after it. An item is taken into an input register, applied to the state by
// compare, increment and flag logic, and its result held in an output register, so
// one item is accepted per cycle while the output side does not stall. The user must
// write configuration only while idle; the block itself does not enforce it.
module vbi_fifo_window_scheduler_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [vfws_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vfws_pkg::TICK_W-1:0]      i_cfg_data,
    vfws_in_if.sink                               i_item,
    vfws_out_if.source                            o_result
);

    logic [vfws_pkg::TICK_W-1:0] r_vbi_ticks, r_fill_ticks, r_warn_ticks;

    logic                        r_in_valid;
    logic [1:0]                  r_in_op;
    logic                        r_in_pin;
    logic [vfws_pkg::PTR_W-1:0]  r_in_widx;

    logic [vfws_pkg::FCNT_W-1:0] r_field_count, n_field_count;
    logic [vfws_pkg::UTC_W-1:0]  r_utc, n_utc;
    logic [vfws_pkg::TICK_W-1:0] r_vbi_count, n_vbi_count;
    logic                        r_vbi_running, n_vbi_running;
    logic [vfws_pkg::TICK_W-1:0] r_fill_count, n_fill_count;
    logic [vfws_pkg::TICK_W-1:0] r_fill_period, n_fill_period;
    logic                        r_fill_running, n_fill_running;
    logic                        r_done, n_done;
    logic                        r_overrun, n_overrun;
    logic                        r_busy, n_busy;
    logic [vfws_pkg::PTR_W-1:0]  r_read_ptr, n_read_ptr;
    logic                        r_select, n_select;
    logic                        n_start;
    logic [vfws_pkg::ADDR_W-1:0] n_addr;

    logic                        r_out_valid;
    logic [vfws_pkg::UTC_W-1:0]  r_out_utc;
    logic                        r_out_done, r_out_overrun, r_out_busy, r_out_start;
    logic                        r_out_select;
    logic [vfws_pkg::PTR_W-1:0]  r_out_ptr;
    logic [vfws_pkg::ADDR_W-1:0] r_out_addr;

    logic                        w_adv;
    logic [vfws_pkg::PTR_W-1:0]  w_next_ptr;
    logic                        w_parity;
    vfws_pkg::t_timer_res        w_vbi_res, w_fill_res;

    assign w_adv          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || w_adv;
    assign w_parity       = ~r_in_pin;
    assign w_next_ptr     = (r_read_ptr == vfws_pkg::PTR_W'(vfws_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_read_ptr + vfws_pkg::PTR_W'(1);

    vfws_tick_timer u_vbi_timer (
        .i_running (r_vbi_running),
        .i_count   (r_vbi_count),
        .i_period  (r_vbi_ticks),
        .o_res     (w_vbi_res)
    );

    vfws_tick_timer u_fill_timer (
        .i_running (r_fill_running),
        .i_count   (r_fill_count),
        .i_period  (r_fill_period),
        .o_res     (w_fill_res)
    );

    always_comb begin
        n_field_count  = r_field_count;
        n_utc          = r_utc;
        n_vbi_count    = r_vbi_count;
        n_vbi_running  = r_vbi_running;
        n_fill_count   = r_fill_count;
        n_fill_period  = r_fill_period;
        n_fill_running = r_fill_running;
        n_done         = r_done;
        n_overrun      = r_overrun;
        n_busy         = r_busy;
        n_read_ptr     = r_read_ptr;
        n_select       = r_select;
        n_start        = 1'b0;
        n_addr         = '0;
        case (vfws_pkg::t_op'(r_in_op))
            vfws_pkg::OP_FIELD: begin
                if (r_field_count + vfws_pkg::FCNT_W'(1)
                        >= vfws_pkg::FCNT_W'(vfws_pkg::FIELDS_PER_SECOND)) begin
                    n_field_count = '0;
                    if (r_utc + vfws_pkg::UTC_W'(1)
                            >= vfws_pkg::UTC_W'(vfws_pkg::SECONDS_PER_DAY)) begin
                        n_utc = '0;
                    end else begin
                        n_utc = r_utc + vfws_pkg::UTC_W'(1);
                    end
                end else begin
                    n_field_count = r_field_count + vfws_pkg::FCNT_W'(1);
                end
                n_vbi_running  = 1'b1;
                n_fill_period  = r_fill_ticks;
                n_fill_running = 1'b1;
            end
            vfws_pkg::OP_TICK: begin
                n_vbi_count  = w_vbi_res.count;
                n_fill_count = w_fill_res.count;
                if (w_vbi_res.expire) begin
                    n_vbi_running = 1'b0;
                    n_overrun     = r_done;
                    n_done        = 1'b1;
                    n_busy        = 1'b0;
                end
                if (w_fill_res.expire) begin
                    if (n_busy) begin
                        n_fill_running = 1'b0;
                        if ((w_next_ptr != r_in_widx) && (w_next_ptr[0] == w_parity)) begin
                            n_start    = 1'b1;
                            n_addr     = vfws_pkg::ADDR_W'(32'(r_read_ptr)
                                       * 32'(vfws_pkg::BLOCK_SIZE));
                            n_select   = 1'b1;
                            n_read_ptr = w_next_ptr;
                        end
                    end else begin
                        n_fill_period = r_warn_ticks;
                    end
                    n_busy = 1'b1;
                end
            end
            vfws_pkg::OP_CLEAR: begin
                n_done = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbi_ticks  <= vfws_pkg::VBI_RESET;
            r_fill_ticks <= vfws_pkg::FILL_RESET;
            r_warn_ticks <= vfws_pkg::WARN_RESET;
        end else if (i_cfg_we) begin
            case (vfws_pkg::t_cfg_idx'(i_cfg_index))
                vfws_pkg::CFG_VBI:  r_vbi_ticks  <= i_cfg_data;
                vfws_pkg::CFG_FILL: r_fill_ticks <= i_cfg_data;
                vfws_pkg::CFG_WARN: r_warn_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
        if (i_item.ready && i_item.valid) begin
            r_in_op   <= i_item.op;
            r_in_pin  <= i_item.field_pin;
            r_in_widx <= i_item.write_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count  <= '0;
            r_utc          <= vfws_pkg::UTC_RESET;
            r_vbi_count    <= '0;
            r_vbi_running  <= 1'b0;
            r_fill_count   <= '0;
            r_fill_period  <= '0;
            r_fill_running <= 1'b0;
            r_done         <= 1'b0;
            r_overrun      <= 1'b0;
            r_busy         <= 1'b0;
            r_read_ptr     <= '0;
            r_select       <= 1'b0;
        end else if (w_adv) begin
            r_field_count  <= n_field_count;
            r_utc          <= n_utc;
            r_vbi_count    <= n_vbi_count;
            r_vbi_running  <= n_vbi_running;
            r_fill_count   <= n_fill_count;
            r_fill_period  <= n_fill_period;
            r_fill_running <= n_fill_running;
            r_done         <= n_done;
            r_overrun      <= n_overrun;
            r_busy         <= n_busy;
            r_read_ptr     <= n_read_ptr;
            r_select       <= n_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_out_utc     <= n_utc;
            r_out_done    <= n_done;
            r_out_overrun <= n_overrun;
            r_out_busy    <= n_busy;
            r_out_ptr     <= n_read_ptr;
            r_out_start   <= n_start;
            r_out_addr    <= n_addr;
            r_out_select  <= n_select;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.utc_seconds  = r_out_utc;
    assign o_result.vbi_done     = r_out_done;
    assign o_result.overrun      = r_out_overrun;
    assign o_result.fifo_busy    = r_out_busy;
    assign o_result.read_index   = r_out_ptr;
    assign o_result.start_read   = r_out_start;
    assign o_result.read_address = r_out_addr;
    assign o_result.tx_select    = r_out_select;

endmodule

`default_nettype wire
